[hw/rtl/dsfe_pkg.sv]
// Shared constants and types for the DLE stuffed frame encoder.
package dsfe_pkg;

  localparam logic [7:0] DLE  = 8'h3D;
  localparam logic [7:0] SOT  = 8'h53;
  localparam logic [7:0] EOT  = 8'h45;
  localparam logic [7:0] MARK = 8'h80;

  // Legacy status codes that get the mark bit at payload byte two
  localparam logic [7:0] CODE_NUL = 8'h00;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_ETX = 8'h03;
  localparam logic [7:0] CODE_LF  = 8'h0A;

  localparam int unsigned MARK_INDEX = 2;

  // Longest burst per payload word: DLE SOT b b sum sum DLE EOT
  localparam int unsigned MAX_BURST = 8;
  localparam int unsigned CNT_W     = $clog2(MAX_BURST + 1);

  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] data;   // data[0] goes out first
    logic [CNT_W-1:0]          count;
    logic                      closes; // burst ends with EOT
  } burst_t;

endpackage

[hw/rtl/dsfe_burst.sv]
// Builds the burst of stream bytes caused by one payload word.
module dsfe_burst #(
  parameter int unsigned PAYLOAD_LEN = 8,
  parameter int unsigned POS_W       = 3
) (
  input  logic [POS_W-1:0]  pos,
  input  logic [7:0]        sum,
  input  logic              compat,
  input  logic [7:0]        payload_byte,
  output logic [7:0]        sum_new,
  output logic              last,
  output dsfe_pkg::burst_t  burst
);

  localparam bit MARK_ON = (PAYLOAD_LEN > dsfe_pkg::MARK_INDEX);

  logic                        first;
  logic                        legacy;
  logic [7:0]                  b_send;
  logic [dsfe_pkg::CNT_W-1:0]  n;

  always_comb begin
    first  = (pos == '0);
    last   = (pos == POS_W'(PAYLOAD_LEN - 1));
    legacy = (payload_byte == dsfe_pkg::CODE_NUL) || (payload_byte == dsfe_pkg::CODE_STX) ||
             (payload_byte == dsfe_pkg::CODE_ETX) || (payload_byte == dsfe_pkg::CODE_LF);
    if (MARK_ON && compat && legacy && (pos == POS_W'(dsfe_pkg::MARK_INDEX))) begin
      b_send = payload_byte | dsfe_pkg::MARK;
    end else begin
      b_send = payload_byte;
    end
    sum_new = sum + b_send;

    n            = '0;
    burst.data   = '0;
    // open the frame
    if (first) begin
      burst.data[n[dsfe_pkg::CNT_W-2:0]] = dsfe_pkg::DLE;
      n = n + 1'b1;
      burst.data[n[dsfe_pkg::CNT_W-2:0]] = dsfe_pkg::SOT;
      n = n + 1'b1;
    end
    // payload word, doubled if DLE
    burst.data[n[dsfe_pkg::CNT_W-2:0]] = b_send;
    n = n + 1'b1;
    if (b_send == dsfe_pkg::DLE) begin
      burst.data[n[dsfe_pkg::CNT_W-2:0]] = b_send;
      n = n + 1'b1;
    end
    // checksum and close
    if (last) begin
      burst.data[n[dsfe_pkg::CNT_W-2:0]] = sum_new;
      n = n + 1'b1;
      if (sum_new == dsfe_pkg::DLE) begin
        burst.data[n[dsfe_pkg::CNT_W-2:0]] = sum_new;
        n = n + 1'b1;
      end
      burst.data[n[dsfe_pkg::CNT_W-2:0]] = dsfe_pkg::DLE;
      n = n + 1'b1;
      burst.data[n[dsfe_pkg::CNT_W-2:0]] = dsfe_pkg::EOT;
      n = n + 1'b1;
    end
    burst.count  = n;
    burst.closes = last;
  end

endmodule

[hw/rtl/dle_stuffed_frame_encoder_top.sv]
// Top level of the DLE stuffed frame encoder: frame state, burst register, output drain.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+-----------
//  input     | in_valid, in_stall, payload_byte          | word in
//  output    | out_valid, out_stall, out_byte, frame_end | word out
//  config    | cfg_write, cfg_data                       | register write
//
// An accepted payload word lands in the burst register as 1 to 8 stream bytes,
// and its first byte is offered in the next cycle. The burst leaves one byte per
// cycle while out_stall is low, so a word holds the block until its last stream byte leaves.
// The next word is taken in the cycle the last byte leaves, so bursts run back to back.
// Reset clears frame position, checksum and burst count; compat mark enable resets to 1.
// A stalled output holds the head byte and blocks new words until the last byte leaves.
module dle_stuffed_frame_encoder_top #(
  parameter int unsigned PAYLOAD_LEN = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] payload_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_end
);

  localparam int unsigned POS_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

  logic                        compat;
  logic [POS_W-1:0]            pos;
  logic [7:0]                  sum;
  dsfe_pkg::burst_t            burst;
  dsfe_pkg::burst_t            burst_new;
  logic [7:0]                  sum_new;
  logic                        last;
  logic                        in_take;
  logic                        out_take;

  dsfe_burst #(
    .PAYLOAD_LEN (PAYLOAD_LEN),
    .POS_W       (POS_W)
  ) u_burst (
    .pos          (pos),
    .sum          (sum),
    .compat       (compat),
    .payload_byte (payload_byte),
    .sum_new      (sum_new),
    .last         (last),
    .burst        (burst_new)
  );

  // Head of the burst register drives the output
  assign out_valid = (burst.count != '0);
  assign out_byte  = burst.data[0];
  assign frame_end = burst.closes && (burst.count == dsfe_pkg::CNT_W'(1));
  assign out_take  = out_valid && !out_stall;

  // Take a new word when the burst register is empty or emptying now
  assign in_stall = (burst.count > dsfe_pkg::CNT_W'(1)) ||
                    ((burst.count == dsfe_pkg::CNT_W'(1)) && out_stall);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      compat <= 1'b1;
    end else if (cfg_write) begin
      compat <= cfg_data;
    end
  end

  // Frame position and checksum advance per accepted word; drop to zero at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
    end else if (in_take) begin
      if (last) begin
        pos <= '0;
        sum <= '0;
      end else begin
        pos <= pos + 1'b1;
        sum <= sum_new;
      end
    end
  end

  // Burst register: load on accept, otherwise shift one byte per taken output byte
  always_ff @(posedge clk) begin
    if (rst) begin
      burst.count <= '0;
    end else if (in_take) begin
      burst.count <= burst_new.count;
    end else if (out_take) begin
      burst.count <= burst.count - 1'b1;
    end
    if (in_take) begin
      burst.data   <= burst_new.data;
      burst.closes <= burst_new.closes;
    end else if (out_take) begin
      for (int unsigned i = 0; i < dsfe_pkg::MAX_BURST - 1; i++) begin
        burst.data[i] <= burst.data[i+1];
      end
      burst.data[dsfe_pkg::MAX_BURST-1] <= '0;
    end
  end

  // The closing word of a frame is always EOT
  a_end_is_eot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (out_byte == dsfe_pkg::EOT))
    else $error("frame_end on a byte other than EOT");

  // Frame state is back at start once the closing word leaves
  a_end_resets_state: assert property (@(posedge clk) disable iff (rst)
    (out_take && frame_end) |-> ((pos == '0) && (sum == '0)))
    else $error("frame state not cleared at frame end");

  // A word at frame start opens its burst with DLE
  a_open_with_dle: assert property (@(posedge clk) disable iff (rst)
    (in_take && (pos == '0)) |=> (out_valid && (out_byte == dsfe_pkg::DLE)))
    else $error("frame did not open with DLE");

endmodule
